// ===== hdl/ajrf_pkg.sv =====
// ajrf_pkg: widths, height bands and hold limits of the altitude jump reject filter
// depends on nothing; used by altitude_jump_reject_filter through scoped names
package ajrf_pkg;

  localparam int ALT_W   = 16;   // altitude word width
  localparam int BAND_W  = 11;   // enough for every band edge up to 1700 m
  localparam int UP_W    = 3;
  localparam int DOWN_W  = 8;
  localparam int LIMIT_W = 8;

  localparam logic [ALT_W-1:0] BAND_10   = ALT_W'(10);
  localparam logic [ALT_W-1:0] BAND_50   = ALT_W'(50);
  localparam logic [ALT_W-1:0] BAND_300  = ALT_W'(300);
  localparam logic [ALT_W-1:0] BAND_600  = ALT_W'(600);
  localparam logic [ALT_W-1:0] BAND_800  = ALT_W'(800);
  localparam logic [ALT_W-1:0] BAND_1700 = ALT_W'(1700);

  localparam logic [ALT_W-1:0] REWIND_BELOW = ALT_W'(20);
  localparam logic [DOWN_W-1:0] REWIND_STEP = DOWN_W'(12);

  localparam logic [UP_W-1:0]   UP_LONG    = UP_W'(5);
  localparam logic [UP_W-1:0]   UP_SHORT   = UP_W'(2);
  localparam logic [DOWN_W-1:0] DOWN_SHORT = DOWN_W'(2);
  localparam logic [DOWN_W-1:0] DOWN_MID   = DOWN_W'(10);

  localparam logic [LIMIT_W-1:0] LONG_HOLD_RESET = LIMIT_W'(80);

  // floor(v/5) for v below 2048: v * ceil(2^18/5) >> 18 is exact over that range
  localparam int RECIP5_SHIFT = 18;
  localparam logic [16:0] RECIP5 = 17'((1 << RECIP5_SHIFT) / 5 + 1);

  function automatic logic [BAND_W-1:0] div5(input logic [BAND_W-1:0] v);
    logic [BAND_W+17-1:0] prod;
    prod = {{17{1'b0}}, v} * {{BAND_W{1'b0}}, RECIP5};
    // quotient is at most 409, so ten bits hold it
    return {1'b0, prod[RECIP5_SHIFT +: BAND_W-1]};
  endfunction

endpackage

// ===== hdl/altitude_jump_reject_filter.sv =====
// altitude jump reject filter: top level, one pass per word from input to output register
// the result word is valid in the cycle after its input word is accepted
// throughput: one word per cycle while the output is not stalled; the whole decision is one
//   layer of compares on the held state
// reset (rst, synchronous): previous output 1, both hold counters 0, long hold limit 80,
//   output register empty
// depends on ajrf_pkg
module altitude_jump_reject_filter (
  input  logic                              clk,
  input  logic                              rst,
  // configuration: long hold limit
  input  logic                              cfg_we,
  input  logic [ajrf_pkg::LIMIT_W-1:0]      cfg_wdata,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [ajrf_pkg::ALT_W-1:0]        s_tdata,   // [15:0] raw_altitude
  // output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ajrf_pkg::ALT_W-1:0]        m_tdata,   // [15:0] filtered_altitude
  output logic                              m_tuser    // [0] held
);

  localparam int AW = ajrf_pkg::ALT_W;
  localparam int BW = ajrf_pkg::BAND_W;

  // filter state
  logic [AW-1:0]                     prev_out;
  logic [ajrf_pkg::UP_W-1:0]         up_cnt;
  logic [ajrf_pkg::DOWN_W-1:0]       down_cnt;
  logic [ajrf_pkg::LIMIT_W-1:0]      long_hold_limit;

  logic [AW-1:0]                     prev_out_next;
  logic [ajrf_pkg::UP_W-1:0]         up_cnt_next;
  logic [ajrf_pkg::DOWN_W-1:0]       down_cnt_next;
  logic                              held_next;

  logic                              s_acc;
  logic [AW-1:0]                     x;
  logic [AW:0]                       margin;
  logic [AW:0]                       p_plus_m;
  logic [AW:0]                       x_plus_m;
  logic [AW:0]                       x_twice;
  logic [AW:0]                       p_ten;
  logic                              rise, fall;
  logic                              big_up, big_down;
  logic                              up1, up2, up3, up4, up_hit;
  logic                              dn1, dn2, dn3, dn4;
  logic [ajrf_pkg::DOWN_W-1:0]       down_inc;

  // output register frees as soon as its word is taken, so the input is ready in every cycle that it is empty or taken
  assign s_tready = !m_tvalid || m_tready;
  assign s_acc    = s_tvalid && s_tready;

  // zero sample counts as one metre
  assign x = (s_tdata == '0) ? AW'(1) : s_tdata;

  // 20% margin only matters up to 1700 m, so the low band bits are enough
  assign margin   = {{(AW+1-BW){1'b0}}, ajrf_pkg::div5(prev_out[BW-1:0])};
  assign p_plus_m = {1'b0, prev_out} + margin;
  assign x_plus_m = {1'b0, x} + margin;
  assign x_twice  = {x, 1'b0};
  // x10 ratio only used while p <= 10, so four bits of p suffice
  assign p_ten    = (AW+1)'({prev_out[3:0], 3'b000}) + (AW+1)'({prev_out[3:0], 1'b0});

  assign rise     = prev_out < x;
  assign fall     = prev_out > x;
  assign big_up   = {1'b0, x} >= p_plus_m;       // x - p >= p/5
  assign big_down = x_plus_m <= {1'b0, prev_out}; // p - x >= p/5

  // upward hold bands, in order
  assign up1 = up_cnt < ajrf_pkg::UP_LONG && prev_out <= ajrf_pkg::BAND_10
               && {1'b0, x} >= p_ten;
  assign up2 = up_cnt < ajrf_pkg::UP_SHORT && prev_out > ajrf_pkg::BAND_10
               && prev_out <= ajrf_pkg::BAND_50 && big_up;
  assign up3 = up_cnt < ajrf_pkg::UP_LONG && prev_out > ajrf_pkg::BAND_50
               && prev_out <= ajrf_pkg::BAND_300 && big_up;
  assign up4 = up_cnt < ajrf_pkg::UP_LONG && prev_out > ajrf_pkg::BAND_300
               && prev_out <= ajrf_pkg::BAND_1700 && big_up;
  assign up_hit = rise && (up1 || up2 || up3 || up4);

  // downward hold bands, in order
  assign dn1 = down_cnt < ajrf_pkg::DOWN_SHORT && prev_out <= ajrf_pkg::BAND_50 && big_down;
  assign dn2 = down_cnt < long_hold_limit && prev_out > ajrf_pkg::BAND_50
               && prev_out <= ajrf_pkg::BAND_800 && {1'b0, prev_out} >= x_twice;
  assign dn3 = down_cnt < ajrf_pkg::DOWN_MID && prev_out > ajrf_pkg::BAND_50
               && prev_out <= ajrf_pkg::BAND_600 && big_down;
  assign dn4 = down_cnt < ajrf_pkg::DOWN_MID && prev_out > ajrf_pkg::BAND_600
               && prev_out <= ajrf_pkg::BAND_1700 && big_down;

  // count is below its limit in every hold branch, so the increment cannot wrap
  assign down_inc = down_cnt + ajrf_pkg::DOWN_W'(1);

  always_comb begin
    up_cnt_next   = '0;
    down_cnt_next = down_cnt;
    held_next     = 1'b1;
    if (up_hit) begin
      up_cnt_next = up_cnt + ajrf_pkg::UP_W'(1);
    end else if (fall && dn1) begin
      down_cnt_next = down_inc;
    end else if (fall && dn2) begin
      // long hold at its limit with a very low sample: rewind (wraps for small limits)
      if (down_inc == long_hold_limit && x < ajrf_pkg::REWIND_BELOW) begin
        down_cnt_next = down_inc - ajrf_pkg::REWIND_STEP;
      end else begin
        down_cnt_next = down_inc;
      end
    end else if (fall && (dn3 || dn4)) begin
      down_cnt_next = down_inc;
    end else begin
      down_cnt_next = '0;
      held_next     = 1'b0;
    end
    prev_out_next = held_next ? prev_out : x;
  end

  // state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_out        <= AW'(1);
      up_cnt          <= '0;
      down_cnt        <= '0;
      long_hold_limit <= ajrf_pkg::LONG_HOLD_RESET;
    end else begin
      if (cfg_we) begin
        long_hold_limit <= cfg_wdata;
      end
      if (s_acc) begin
        prev_out <= prev_out_next;
        up_cnt   <= up_cnt_next;
        down_cnt <= down_cnt_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_acc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      m_tdata <= prev_out_next;
      m_tuser <= held_next;
    end
  end

  // a held word repeats the output from before it
  a_held_repeats: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> (!m_tuser || m_tdata == $past(prev_out)))
    else $error("held word does not repeat previous output");

  // an accepted sample clears both hold counters and becomes the state
  a_pass_clears: assert property (@(posedge clk) disable iff (rst)
    (s_acc && !held_next) |=> (up_cnt == '0 && down_cnt == '0 && prev_out == m_tdata))
    else $error("passed sample did not clear hold state");

  // the upward hold never runs past five samples
  a_up_bound: assert property (@(posedge clk) disable iff (rst)
    up_cnt <= ajrf_pkg::UP_LONG)
    else $error("upward hold count out of range");

  // output state is never zero
  a_prev_nonzero: assert property (@(posedge clk) disable iff (rst)
    prev_out != '0)
    else $error("previous output is zero");

endmodule

// ===== verif/altitude_jump_reject_filter_checker.sv =====
// watcher for the altitude jump reject filter: follows the config port and both streams,
// predicts every result word and compares it with what the filter hands out
// depends on ajrf_pkg for port widths
module altitude_jump_reject_filter_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [ajrf_pkg::LIMIT_W-1:0] cfg_wdata,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [ajrf_pkg::ALT_W-1:0]   s_tdata,   // [15:0] raw_altitude
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [ajrf_pkg::ALT_W-1:0]   m_tdata,   // [15:0] filtered_altitude
  input  logic                         m_tuser,   // [0] held
  output int                           fail_count,
  output int                           outstanding,
  output int                           results_checked,
  output int                           holds_seen,
  output int                           rewinds_seen
);

  typedef struct packed {
    logic [15:0] alt;
    logic        held;
  } alt_result_t;

  alt_result_t pending_filtered[$];

  logic [15:0] last_alt;
  logic [2:0]  up_count;
  logic [7:0]  down_count;
  logic [7:0]  hold_limit;

  // one sample through the jump tests, updating the tracked state
  task automatic judge_sample(input logic [15:0] raw, output alt_result_t res);
    int unsigned p;
    int unsigned x;
    int unsigned margin;
    logic        up_hold;
    logic        down_hold;
    p = last_alt;
    x = (raw == 16'd0) ? 1 : raw;
    margin = p / 5;
    up_hold = 1'b0;
    down_hold = 1'b0;
    if (p < x) begin
      if (up_count < 5 && p <= 10 && x >= 10 * p)
        up_hold = 1'b1;
      else if (up_count < 2 && p > 10 && p <= 50 && x - p >= margin)
        up_hold = 1'b1;
      else if (up_count < 5 && p > 50 && p <= 1700 && x - p >= margin)
        up_hold = 1'b1;
    end
    if (up_hold) begin
      up_count = up_count + 3'd1;
    end else begin
      up_count = 3'd0;
      if (p > x) begin
        if (down_count < 2 && p <= 50 && p - x >= margin) begin
          down_hold = 1'b1;
          down_count = down_count + 8'd1;
        end else if (down_count < hold_limit && p > 50 && p <= 800 && p >= 2 * x) begin
          down_hold = 1'b1;
          down_count = down_count + 8'd1;
          // long hold rewinds at its limit for very low readings
          if (down_count == hold_limit && x < 20) begin
            down_count = down_count - 8'd12;
            rewinds_seen++;
          end
        end else if (down_count < 10 && p > 50 && p <= 1700 && p - x >= margin) begin
          down_hold = 1'b1;
          down_count = down_count + 8'd1;
        end
      end
      if (!down_hold)
        down_count = 8'd0;
    end
    if (!(up_hold || down_hold))
      last_alt = x[15:0];
    res.alt = last_alt;
    res.held = up_hold || down_hold;
  endtask

  always @(posedge clk) begin
    alt_result_t want;
    if (rst) begin
      last_alt = 16'd1;
      up_count = 3'd0;
      down_count = 8'd0;
      hold_limit = 8'd80;
      pending_filtered.delete();
      fail_count = 0;
      results_checked = 0;
      holds_seen = 0;
      rewinds_seen = 0;
    end else begin
      if (cfg_we)
        hold_limit = cfg_wdata;
      if (m_tvalid && m_tready) begin
        if (pending_filtered.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected word, expected none, got altitude %0d held %0b",
                   $time, m_tdata, m_tuser);
        end else begin
          want = pending_filtered.pop_front();
          results_checked++;
          if (want.alt !== m_tdata) begin
            fail_count++;
            $display("%0t: filtered_altitude expected %0d got %0d", $time, want.alt, m_tdata);
          end
          if (want.held !== m_tuser) begin
            fail_count++;
            $display("%0t: held expected %0b got %0b", $time, want.held, m_tuser);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        judge_sample(s_tdata, want);
        if (want.held)
          holds_seen++;
        pending_filtered.push_back(want);
      end
    end
    outstanding = pending_filtered.size();
  end

endmodule

// ===== verif/altitude_jump_reject_filter_test.sv =====
// testbench top for the altitude jump reject filter: clock, reset, stimulus and verdict
// depends on ajrf_pkg, altitude_jump_reject_filter and altitude_jump_reject_filter_checker
module altitude_jump_reject_filter_test;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // config port, long hold limit
  logic                         cfg_we = 1'b0;
  logic [ajrf_pkg::LIMIT_W-1:0] cfg_wdata = '0;

  // input stream
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [ajrf_pkg::ALT_W-1:0] s_tdata = '0;   // [15:0] raw_altitude

  // output stream
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [ajrf_pkg::ALT_W-1:0] m_tdata;        // [15:0] filtered_altitude
  logic                       m_tuser;        // [0] held

  int fail_count;
  int outstanding;
  int results_checked;
  int holds_seen;
  int rewinds_seen;

  // idling knobs, percent of cycles
  int gap_pct = 0;
  int stall_pct = 0;

  // long receiver hold-off, armed once by the stimulus and counted by the receiver
  logic hold_off_arm = 1'b0;
  logic hold_off_done = 1'b0;
  int   hold_off_left = 0;

  int          words_sent = 0;
  int          long_limit = 80;   // what the long hold limit is currently set to
  logic [15:0] track = 16'd1;     // rough idea of the filter's last output

  always #4 clk = ~clk;

  altitude_jump_reject_filter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  altitude_jump_reject_filter_checker chk (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .holds_seen      (holds_seen),
    .rewinds_seen    (rewinds_seen)
  );

  // receiver: random stalls, plus one long hold-off so the filter backs up
  always @(posedge clk) begin
    if (hold_off_arm && !hold_off_done) begin
      hold_off_left <= 64;
      hold_off_done <= 1'b1;
      m_tready <= 1'b0;
    end else if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // offer one word, with random idle cycles in front, and wait for it to be taken
  task automatic send_word(input logic [15:0] raw);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= raw;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    words_sent++;
  endtask

  task automatic send_run(input logic [15:0] raw, input int n);
    repeat (n) send_word(raw);
  endtask

  // stop offering until every predicted word has come back, then realign to the clock
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // only called with the filter drained
  task automatic write_limit(input int v);
    cfg_we <= 1'b1;
    cfg_wdata <= 8'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    long_limit = v;
  endtask

  // a starting height from one of the bands the filter tells apart
  function automatic logic [15:0] band_base();
    case ($urandom_range(7))
      0:       return 16'($urandom_range(1, 10));
      1:       return 16'($urandom_range(11, 50));
      2:       return 16'($urandom_range(51, 300));
      3:       return 16'($urandom_range(301, 600));
      4:       return 16'($urandom_range(601, 800));
      5:       return 16'($urandom_range(801, 1700));
      6:       return 16'($urandom_range(1701, 65535));
      default: return 16'($urandom_range(0, 19));
    endcase
  endfunction

  // settle on a height, then a string of drifts, jumps held for a while, zeros and noise
  task automatic altitude_burst();
    int cand;
    int margin;
    int n;
    int steps;
    track = band_base();
    send_run(track, $urandom_range(1, 3));
    steps = $urandom_range(3, 10);
    repeat (steps) begin
      margin = track / 5;
      n = $urandom_range(1, 8);
      case ($urandom_range(9))
        0, 1, 2: begin
          // drift inside the margin, normally accepted
          n = 1;
          if (margin == 0)
            cand = track;
          else if ($urandom_range(1))
            cand = track + $urandom_range(0, margin - 1);
          else
            cand = track - $urandom_range(0, margin - 1);
        end
        3, 4: begin
          // upward jump at or just past the threshold
          if (track <= 10)
            cand = 10 * track + $urandom_range(0, 2);
          else
            cand = track + margin + $urandom_range(0, 2);
        end
        5, 6: begin
          // downward jump around the margin
          cand = track - margin - $urandom_range(0, 2);
          n = $urandom_range(1, 12);
        end
        7: begin
          // halving or worse, often very low to reach the rewind
          if ($urandom_range(1))
            cand = $urandom_range(0, 19);
          else
            cand = track / 2 - $urandom_range(0, 2);
          n = ($urandom_range(7) == 0) ? long_limit + 2 : $urandom_range(1, 14);
        end
        8:       cand = 0;
        default: cand = $urandom_range(0, 65535);
      endcase
      if (cand < 0)
        cand = 0;
      if (cand > 65535)
        cand = 65535;
      send_run(16'(cand), n);
      if (n > 1 || $urandom_range(1))
        track = (cand == 0) ? 16'd1 : 16'(cand);
    end
  endtask

  // hard stop if the handshakes never finish
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int          phase_limit[10];
    logic [15:0] directed_words[25];
    int          phase_start;
    logic        paused;
    // reset default first, then the extremes, the rewind corner cases, one random value and the default again
    phase_limit = '{80, 1, 255, 0, 11, 12, 5, 20, -1, 80};
    // zero, full scale, ratio holds from the floor, band edges at 10, 50 and 1700
    directed_words = '{16'd0, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
                       16'd65535, 16'd65535, 16'd0, 16'd9, 16'd90, 16'd89,
                       16'd107, 16'd106, 16'd105, 16'd40, 16'd84, 16'd90,
                       16'd12, 16'd45, 16'd50, 16'd61, 16'd1700, 16'd2100,
                       16'd1701, 16'd2100};
    paused = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < 10; ph++) begin
      if (ph > 0) begin
        wait_drained();
        write_limit((phase_limit[ph] < 0) ? $urandom_range(13, 254) : phase_limit[ph]);
      end
      // idling pattern rotates: none, sender gaps, receiver stalls, a little of both
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 60; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 60; end
        default: begin gap_pct = 6; stall_pct = 6; end
      endcase
      if (ph == 0)
        foreach (directed_words[i])
          send_word(directed_words[i]);
      phase_start = words_sent;
      while (words_sent - phase_start < 90) begin
        if (ph == 4)
          hold_off_arm <= 1'b1;
        // one pause mid-stream until the filter has handed back everything
        if (ph == 5 && !paused && words_sent - phase_start >= 60) begin
          wait_drained();
          paused = 1'b1;
        end
        altitude_burst();
      end
    end

    gap_pct = 0;
    stall_pct = 0;
    wait_drained();
    // keep the clock running a little longer to catch any stray output word
    repeat (4) @(posedge clk);

    $display("covered %0d input words and %0d checked results, %0d of them held",
             words_sent, results_checked, holds_seen);
    $display("ten long hold limits from 0 to 255, %0d long hold rewinds, four idling patterns",
             rewinds_seen);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
